@@ rtl/first_fit_block_allocator_assert.svh @@
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("allocator assertion failed");
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("allocator assertion failed");
`else
`define FFBA_ASSERT(label, clk, rst_n, prop)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

@@ rtl/ffba_pkg.sv @@
// Types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 32;

  localparam logic [31:0] RST_HEAP_BASE   = 32'd4096;
  localparam logic [31:0] RST_HEAP_LIMIT  = 32'd16777216;
  localparam logic [31:0] RST_MAX_REQUEST = 32'd100000000;

  localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_MAX_REQUEST = 2'd2;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_ZALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;
  localparam logic [1:0] REQ_RESIZE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SIZE    = 2'd1;
  localparam logic [1:0] ST_SPACE   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        is_free;
    logic [31:0] bytes;
    logic [31:0] start;
  } blk_t;

endpackage

@@ rtl/first_fit_block_allocator.sv @@
// First-fit block allocator: block table in RAM, scanned one entry per cycle.
// Flow: a rejected size or null free goes from the check to the result; a zeroed allocate
// multiplies first. Allocate scans the used blocks for the first free block that fits, else
// appends at the break; free looks up its block; a moving resize finds, allocates, frees.
// Busy stays high through out_valid; a new start is taken only while idle.
// Results are never held off. Reset: config and counters to defaults, break to 4096.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_byte_size,
  input  logic [31:0] in_elem_count,
  input  logic [31:0] in_payload_addr,
  output logic        out_valid,
  output logic [31:0] out_result_addr,
  output logic [1:0]  out_status,
  output logic [6:0]  out_free_block_total,
  output logic [31:0] out_free_byte_total,
  output logic [6:0]  out_block_total,
  output logic [31:0] out_byte_total,
  output logic [11:0] out_header_byte_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffba_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_FIND   = 4'd3;
  localparam logic [3:0] S_FIT    = 4'd4;
  localparam logic [3:0] S_GROW   = 4'd5;
  localparam logic [3:0] S_APPEND = 4'd6;
  localparam logic [3:0] S_FREE   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // block table
  blk_t mem [MAX_BLOCKS];
  blk_t rd_data_r;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  blk_t wr_word;

  logic [3:0] state_r, state_nxt;
  logic [1:0] type_r, type_nxt;
  logic [31:0] s_r, s_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic ovf_r, ovf_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0] st_r, st_nxt;
  logic has_old_r, has_old_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  blk_t old_word_r, old_word_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic cmp_vld_r, cmp_vld_nxt;
  logic [33:0] end_r, end_nxt;

  logic [31:0] limit_r, maxreq_r;
  logic [31:0] break_r, break_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [31:0] free_bytes_r, free_bytes_nxt;
  logic [31:0] all_bytes_r, all_bytes_nxt;

  logic [63:0] prod;
  logic size_ok;
  logic find_hit, fit_hit, scan_done;
  logic cfg_we;

  assign prod      = 64'(s_r) * 64'(count_r);
  assign size_ok   = !ovf_r && (s_r != 32'd0) && (s_r < maxreq_r);
  assign find_hit  = cmp_vld_r && ((rd_data_r.start + HDR32) == addr_r);
  assign fit_hit   = cmp_vld_r && rd_data_r.is_free && (rd_data_r.bytes >= s_r);
  assign scan_done = !cmp_vld_r && (scan_idx_r >= used_r);
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    state_nxt      = state_r;
    type_nxt       = type_r;
    s_nxt          = s_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    ovf_nxt        = ovf_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    has_old_nxt    = has_old_r;
    old_idx_nxt    = old_idx_r;
    old_word_nxt   = old_word_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    end_nxt        = end_r;
    break_nxt      = break_r;
    used_nxt       = used_r;
    free_cnt_nxt   = free_cnt_r;
    free_bytes_nxt = free_bytes_r;
    all_bytes_nxt  = all_bytes_r;
    wr_en          = 1'b0;
    wr_idx         = cmp_idx_r;
    wr_word        = rd_data_r;

    // scan pipeline: issue one read a cycle, compare the previous beat
    if (state_r == S_FIND || state_r == S_FIT) begin
      cmp_idx_nxt = scan_idx_r[IDX_W-1:0];
      if (scan_idx_r < used_r) begin
        cmp_vld_nxt  = 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          type_nxt    = in_req_type;
          s_nxt       = in_byte_size;
          count_nxt   = in_elem_count;
          addr_nxt    = in_payload_addr;
          ovf_nxt     = 1'b0;
          res_nxt     = 32'd0;
          st_nxt      = ST_OK;
          has_old_nxt = 1'b0;
          state_nxt   = (in_req_type == REQ_ZALLOC) ? S_MUL : S_CHK;
        end
      end
      S_MUL: begin
        s_nxt     = prod[31:0];
        ovf_nxt   = |prod[63:32];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        scan_idx_nxt = '0;
        if (type_r == REQ_FREE) begin
          state_nxt = (addr_r == 32'd0) ? S_DONE : S_FIND;
        end else if (!size_ok) begin
          st_nxt    = ST_SIZE;
          state_nxt = S_DONE;
        end else if (type_r == REQ_RESIZE && addr_r != 32'd0) begin
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_FIT;
        end
      end
      S_FIND: begin
        if (find_hit) begin
          cmp_vld_nxt  = 1'b0;
          scan_idx_nxt = '0;
          old_idx_nxt  = cmp_idx_r;
          old_word_nxt = rd_data_r;
          if (type_r == REQ_FREE) begin
            state_nxt = S_FREE;
          end else if (rd_data_r.bytes >= s_r) begin
            res_nxt   = addr_r;
            state_nxt = S_DONE;
          end else begin
            has_old_nxt = 1'b1;
            state_nxt   = S_FIT;
          end
        end else if (scan_done) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_DONE;
        end
      end
      S_FIT: begin
        if (fit_hit) begin
          cmp_vld_nxt     = 1'b0;
          wr_en           = 1'b1;
          wr_idx          = cmp_idx_r;
          wr_word         = rd_data_r;
          wr_word.is_free = 1'b0;
          free_cnt_nxt    = free_cnt_r - 1'b1;
          free_bytes_nxt  = free_bytes_r - rd_data_r.bytes;
          res_nxt         = rd_data_r.start + HDR32;
          state_nxt       = has_old_r ? S_FREE : S_DONE;
        end else if (scan_done) begin
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        end_nxt   = {2'b00, break_r} + HDR34 + {2'b00, s_r};
        state_nxt = S_APPEND;
      end
      S_APPEND: begin
        if (used_r >= MAX_CNT || end_r > {2'b00, limit_r}) begin
          st_nxt    = ST_SPACE;
          state_nxt = S_DONE;
        end else begin
          wr_en           = 1'b1;
          wr_idx          = used_r[IDX_W-1:0];
          wr_word.is_free = 1'b0;
          wr_word.bytes   = s_r;
          wr_word.start   = break_r;
          used_nxt        = used_r + 1'b1;
          all_bytes_nxt   = all_bytes_r + s_r;
          res_nxt         = break_r + HDR32;
          break_nxt       = end_r[31:0];
          state_nxt       = has_old_r ? S_FREE : S_DONE;
        end
      end
      S_FREE: begin
        if (!old_word_r.is_free) begin
          wr_en           = 1'b1;
          wr_idx          = old_idx_r;
          wr_word         = old_word_r;
          wr_word.is_free = 1'b1;
          free_cnt_nxt    = free_cnt_r + 1'b1;
          free_bytes_nxt  = free_bytes_r + old_word_r.bytes;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // moving the base only drags the break along while the table is empty
    if (cfg_we && cfg_index == REG_HEAP_BASE && used_r == '0) begin
      break_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_vld_r    <= 1'b0;
      scan_idx_r   <= '0;
      has_old_r    <= 1'b0;
      limit_r      <= RST_HEAP_LIMIT;
      maxreq_r     <= RST_MAX_REQUEST;
      break_r      <= RST_HEAP_BASE;
      used_r       <= '0;
      free_cnt_r   <= '0;
      free_bytes_r <= '0;
      all_bytes_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      scan_idx_r   <= scan_idx_nxt;
      has_old_r    <= has_old_nxt;
      break_r      <= break_nxt;
      used_r       <= used_nxt;
      free_cnt_r   <= free_cnt_nxt;
      free_bytes_r <= free_bytes_nxt;
      all_bytes_r  <= all_bytes_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_LIMIT:  limit_r  <= cfg_data;
          REG_MAX_REQUEST: maxreq_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    s_r        <= s_nxt;
    count_r    <= count_nxt;
    addr_r     <= addr_nxt;
    ovf_r      <= ovf_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    old_idx_r  <= old_idx_nxt;
    old_word_r <= old_word_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    end_r      <= end_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_result_addr       = res_r;
  assign out_status            = st_r;
  assign out_free_block_total  = 7'(free_cnt_r);
  assign out_free_byte_total   = free_bytes_r;
  assign out_block_total       = 7'(used_r);
  assign out_byte_total        = all_bytes_r;
  assign out_header_byte_total = 12'(32'(used_r) * HDR32);

  `FFBA_ASSERT_NEXT(a_done_to_idle, clk, rst_n, out_valid, !busy)
  `FFBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FFBA_ASSERT(a_free_le_used, clk, rst_n, free_cnt_r <= used_r)
  `FFBA_ASSERT(a_used_le_max, clk, rst_n, used_r <= MAX_CNT)
  `FFBA_ASSERT(a_cmp_in_table, clk, rst_n, !cmp_vld_r || (CNT_W'(cmp_idx_r) < used_r))

endmodule
